// ----- rtl/core/mkar_pkg.sv -----
package mkar_pkg;

    localparam int NUM_KEYS_DEF = 16;
    localparam int CODE_W       = 4;
    localparam int OP_W         = 2;
    localparam int CNT_W        = 16;

    localparam logic [OP_W-1:0] OP_PRESS   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

    localparam logic CFG_DELAY  = 1'b0;
    localparam logic CFG_PERIOD = 1'b1;

    localparam logic [CNT_W-1:0] DELAY_RST  = 16'd20;
    localparam logic [CNT_W-1:0] PERIOD_RST = 16'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

endpackage

// ----- rtl/core/multi_key_auto_repeat.sv -----
// Channel   Direction  Handshake               Payload
// input     in         i_valid / o_ready       i_op, i_key
// result    out        o_valid / i_ready       o_event_code, o_last
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Press: accept, then the result moves to the output register in ST_FLUSH, waiting while
// that register is full. Release and unused ops: accept only. Tick: accept, a RAM read,
// one key entry per cycle through the count/phase RAM unless a due key waits on a full
// output register, then a drain step and a flush step.
// Reset is synchronous: clears held marks and control, loads config defaults; RAM needs no clear
// since a press initialises an entry before its contents are ever used.
module multi_key_auto_repeat #(
    parameter int NUM_KEYS = mkar_pkg::NUM_KEYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mkar_pkg::OP_W-1:0]   i_op,
    input  logic [mkar_pkg::CODE_W-1:0] i_key,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mkar_pkg::CODE_W-1:0] o_event_code,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [mkar_pkg::CNT_W-1:0]  i_cfg_data
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CW = mkar_pkg::CODE_W;
    localparam int VW = mkar_pkg::CNT_W;
    localparam logic [KW-1:0] LAST_IDX = KW'(NUM_KEYS - 1);

    mkar_pkg::t_state r_state, n_state;

    logic [VW-1:0]       r_delay, r_period;
    logic [NUM_KEYS-1:0] r_held;
    logic [2*VW-1:0]     mem [NUM_KEYS];
    logic [2*VW-1:0]     r_rdata;

    logic          r_issuing;
    logic [KW-1:0] r_rd_idx;
    logic          r_s1_valid;
    logic [KW-1:0] r_s1_idx;

    logic          r_pend_valid;
    logic [CW-1:0] r_pend_code;
    logic          r_o_valid;
    logic [CW-1:0] r_o_code;
    logic          r_o_last;

    // combinational
    logic             out_free, in_take, key_ok;
    logic [KW+CW-1:0] key_ext, idx_ext;
    logic [KW-1:0]    key_idx;
    logic [CW-1:0]    s1_code;
    logic [VW-1:0]    s1_cnt, s1_ph;
    logic [VW:0]      ph_nx;
    logic             s1_held, s1_due, stall, walk_go, walk_done;
    logic             press_go, rel_go, tick_go;
    logic             mem_re, mem_we;
    logic [KW-1:0]    waddr;
    logic [2*VW-1:0]  wdata;
    logic             ld_walk, ld_flush;

    assign key_ext = {{KW{1'b0}}, i_key};
    assign key_idx = key_ext[KW-1:0];
    assign idx_ext = {{CW{1'b0}}, r_s1_idx};
    assign s1_code = idx_ext[CW-1:0];
    assign s1_cnt  = r_rdata[2*VW-1:VW];
    assign s1_ph   = r_rdata[VW-1:0];
    assign ph_nx   = {1'b0, s1_ph} + {{VW{1'b0}}, 1'b1};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mkar_pkg::ST_IDLE: begin
                if (press_go) begin
                    n_state = mkar_pkg::ST_FLUSH;
                end else if (tick_go) begin
                    n_state = mkar_pkg::ST_WALK;
                end
            end
            mkar_pkg::ST_WALK: begin
                if (walk_done) begin
                    n_state = mkar_pkg::ST_FLUSH;
                end
            end
            mkar_pkg::ST_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = mkar_pkg::ST_IDLE;
                end
            end
            default: n_state = mkar_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = (r_state == mkar_pkg::ST_IDLE);
        out_free  = !r_o_valid || i_ready;
        in_take   = i_valid && o_ready;
        key_ok    = (int'(i_key) < NUM_KEYS);
        press_go  = in_take && (i_op == mkar_pkg::OP_PRESS) && key_ok;
        rel_go    = in_take && (i_op == mkar_pkg::OP_RELEASE) && key_ok;
        tick_go   = in_take && (i_op == mkar_pkg::OP_TICK);
        s1_held   = r_held[r_s1_idx];
        s1_due    = r_s1_valid && s1_held && (s1_cnt >= r_delay) && (s1_ph == '0);
        stall     = s1_due && r_pend_valid && !out_free;
        walk_go   = (r_state == mkar_pkg::ST_WALK) && !stall;
        walk_done = (r_state == mkar_pkg::ST_WALK) && !r_issuing && !r_s1_valid;
        mem_re    = walk_go && r_issuing;
        ld_walk   = walk_go && s1_due && r_pend_valid;
        ld_flush  = (r_state == mkar_pkg::ST_FLUSH) && r_pend_valid && out_free;
        mem_we    = press_go || (walk_go && r_s1_valid && s1_held);
        waddr     = press_go ? key_idx : r_s1_idx;
        if (press_go) begin
            wdata = '0;
        end else if (s1_cnt < r_delay) begin
            wdata = {s1_cnt + {{(VW-1){1'b0}}, 1'b1}, s1_ph};
        end else if (ph_nx >= {1'b0, r_period}) begin
            wdata = {s1_cnt, {VW{1'b0}}};
        end else begin
            wdata = {s1_cnt, ph_nx[VW-1:0]};
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_o_valid;
    assign o_event_code = r_o_code;
    assign o_last       = r_o_last;

    // count/phase RAM
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mkar_pkg::ST_IDLE;
            r_delay      <= mkar_pkg::DELAY_RST;
            r_period     <= mkar_pkg::PERIOD_RST;
            r_held       <= '0;
            r_issuing    <= 1'b0;
            r_rd_idx     <= '0;
            r_s1_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == mkar_pkg::CFG_DELAY) begin
                    r_delay <= i_cfg_data;
                end else begin
                    r_period <= i_cfg_data;
                end
            end
            if (press_go) begin
                r_held[key_idx] <= 1'b1;
            end else if (rel_go) begin
                r_held[key_idx] <= 1'b0;
            end
            if (tick_go) begin
                r_issuing <= 1'b1;
                r_rd_idx  <= '0;
            end else if (mem_re) begin
                if (r_rd_idx == LAST_IDX) begin
                    r_issuing <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + {{(KW-1){1'b0}}, 1'b1};
                end
            end
            if (walk_go) begin
                r_s1_valid <= r_issuing;
            end
            if (press_go || (walk_go && s1_due)) begin
                r_pend_valid <= 1'b1;
            end else if (ld_flush) begin
                r_pend_valid <= 1'b0;
            end
            if (ld_walk || ld_flush) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_go) begin
            r_s1_idx <= r_rd_idx;
        end
        if (press_go) begin
            r_pend_code <= i_key;
        end else if (walk_go && s1_due) begin
            r_pend_code <= s1_code;
        end
        if (ld_walk || ld_flush) begin
            r_o_code <= r_pend_code;
            r_o_last <= ld_flush;
        end
    end

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mkar_pkg::ST_IDLE) |-> !r_pend_valid)
        else $error("pending request left over in idle");

    a_s1_only_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mkar_pkg::ST_WALK) |-> !r_s1_valid)
        else $error("walk stage busy outside walk");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (waddr != r_rd_idx))
        else $error("RAM read and write to same entry");

    a_press_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        press_go |=> (r_pend_valid && (r_state == mkar_pkg::ST_FLUSH)))
        else $error("press did not queue its request");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int N_KEYS = mkar_pkg::NUM_KEYS_DEF;
    localparam int KEY_W  = mkar_pkg::CODE_W;
    localparam logic [mkar_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    // a tick walks every key entry, then the result register drains
    localparam int DRAIN_CYC = 2 * N_KEYS + 8;
    localparam int RX_HOLD_CYC = 300;
    localparam int N_PHASES = 8;
    localparam int REQS_PER_PHASE = 16;
    localparam int EXP_DEPTH = 64;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic [mkar_pkg::OP_W-1:0]     i_op        = mkar_pkg::OP_TICK;
    logic [mkar_pkg::CODE_W-1:0]   i_key       = '0;
    logic                          i_ready     = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          i_cfg_index = mkar_pkg::CFG_DELAY;
    logic [mkar_pkg::CNT_W-1:0]    i_cfg_data  = '0;
    logic                          o_ready;
    logic                          o_valid;
    logic [mkar_pkg::CODE_W-1:0]   o_event_code;
    logic                          o_last;
    logic                          o_cfg_ready;

    multi_key_auto_repeat u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_key        (i_key),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_event_code (o_event_code),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    typedef struct packed {
        logic [mkar_pkg::CODE_W-1:0] code;
        logic                        last;
    } t_emit;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [mkar_pkg::OP_W-1:0]   op;
        logic [mkar_pkg::CODE_W-1:0] key;
        logic                        idx;
        logic [mkar_pkg::CNT_W-1:0]  data;
        logic                        typed;
        logic [4:0]                  exp_n;
        logic [mkar_pkg::CODE_W-1:0] exp_code;
    } t_row;

    t_row dir_tab [27] = '{
        '{ROW_ITEM, mkar_pkg::OP_PRESS,   4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b1, 5'd1, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_PRESS,   4'd15, mkar_pkg::CFG_DELAY,  16'd0, 1'b1, 5'd1, 4'd15},
        '{ROW_ITEM, mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b1, 5'd0, 4'd0},
        '{ROW_ITEM, OP_UNUSED,            4'd7,  mkar_pkg::CFG_DELAY,  16'd0, 1'b1, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_RELEASE, 4'd9,  mkar_pkg::CFG_DELAY,  16'd0, 1'b1, 5'd0, 4'd0},
        '{ROW_CFG,  mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b0, 5'd0, 4'd0},
        '{ROW_CFG,  mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_PERIOD, 16'd1, 1'b0, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_TICK,    4'd10, mkar_pkg::CFG_DELAY,  16'd0, 1'b0, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_PRESS,   4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b1, 5'd1, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_TICK,    4'd5,  mkar_pkg::CFG_DELAY,  16'd0, 1'b0, 5'd0, 4'd0},
        '{ROW_CFG,  mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_PERIOD, 16'd0, 1'b0, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b0, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_TICK,    4'd15, mkar_pkg::CFG_DELAY,  16'd0, 1'b0, 5'd0, 4'd0},
        '{ROW_CFG,  mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_DELAY,  16'd3, 1'b0, 5'd0, 4'd0},
        '{ROW_CFG,  mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_PERIOD, 16'd2, 1'b0, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_PRESS,   4'd7,  mkar_pkg::CFG_DELAY,  16'd0, 1'b1, 5'd1, 4'd7},
        '{ROW_ITEM, mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b0, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b0, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b0, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b0, 5'd0, 4'd0},
        '{ROW_CFG,  mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_DELAY,  16'd1, 1'b0, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b0, 5'd0, 4'd0},
        '{ROW_CFG,  mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_PERIOD, 16'd1, 1'b0, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b0, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_RELEASE, 4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b1, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_RELEASE, 4'd15, mkar_pkg::CFG_DELAY,  16'd0, 1'b1, 5'd0, 4'd0},
        '{ROW_ITEM, mkar_pkg::OP_TICK,    4'd0,  mkar_pkg::CFG_DELAY,  16'd0, 1'b0, 5'd0, 4'd0}
    };

    logic [mkar_pkg::CNT_W-1:0] ph_delay  [N_PHASES] = '{16'd0, 16'd2, 16'd1, 16'd5,
                                                         16'd65535, 16'd0, 16'd3, 16'd20};
    logic [mkar_pkg::CNT_W-1:0] ph_period [N_PHASES] = '{16'd1, 16'd3, 16'd0, 16'd2,
                                                         16'd65535, 16'd65535, 16'd1, 16'd4};

    // predicted key state and registers
    logic                       key_held  [N_KEYS];
    logic [mkar_pkg::CNT_W-1:0] key_count [N_KEYS];
    logic [mkar_pkg::CNT_W-1:0] key_phase [N_KEYS];
    logic [mkar_pkg::CNT_W-1:0] cfg_delay;
    logic [mkar_pkg::CNT_W-1:0] cfg_period;

    // expected results, ring buffer
    t_emit exp_buf [EXP_DEPTH];
    int    exp_wr = 0;
    int    exp_rd = 0;
    t_emit step_buf [N_KEYS];
    int    step_n = 0;
    int    err_cnt = 0;
    int    hold_req = 0;
    int    hold_ack = 0;
    int    rx_hold_left = 0;
    int    rx_stall_left = 0;
    logic [15:0] rx_cyc = '0;

    function automatic void clear_keys();
        for (int i = 0; i < N_KEYS; i++) begin
            key_held[i]  = 1'b0;
            key_count[i] = '0;
            key_phase[i] = '0;
        end
        cfg_delay  = mkar_pkg::DELAY_RST;
        cfg_period = mkar_pkg::PERIOD_RST;
    endfunction

    function automatic void exp_put(t_emit e);
        exp_buf[exp_wr % EXP_DEPTH] = e;
        exp_wr++;
    endfunction

    // fills step_buf with the codes one request gives
    function automatic void predict_keys(logic [mkar_pkg::OP_W-1:0] op,
                                         logic [mkar_pkg::CODE_W-1:0] key);
        logic [mkar_pkg::CNT_W:0] nxt;
        step_n = 0;
        case (op)
            mkar_pkg::OP_PRESS: begin
                key_held[key]  = 1'b1;
                key_count[key] = '0;
                key_phase[key] = '0;
                step_buf[0]    = t_emit'{key, 1'b0};
                step_n         = 1;
            end
            mkar_pkg::OP_RELEASE: begin
                key_held[key] = 1'b0;
            end
            mkar_pkg::OP_TICK: begin
                for (int i = 0; i < N_KEYS; i++) begin
                    if (key_held[i]) begin
                        if (key_count[i] >= cfg_delay && key_phase[i] == '0) begin
                            step_buf[step_n] = t_emit'{i[mkar_pkg::CODE_W-1:0], 1'b0};
                            step_n++;
                        end
                        if (key_count[i] < cfg_delay) begin
                            key_count[i] = key_count[i] + 1'b1;
                        end else begin
                            nxt = {1'b0, key_phase[i]} + 1'b1;
                            key_phase[i] = (nxt >= {1'b0, cfg_period}) ? '0
                                                                       : nxt[mkar_pkg::CNT_W-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase
        if (step_n > 0)
            step_buf[step_n - 1].last = 1'b1;
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    task automatic send_req(input logic [mkar_pkg::OP_W-1:0] op,
                            input logic [mkar_pkg::CODE_W-1:0] key, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [mkar_pkg::CNT_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == mkar_pkg::CFG_DELAY)
            cfg_delay = data;
        else
            cfg_period = data;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic issue_req(input logic [mkar_pkg::OP_W-1:0] op,
                             input logic [mkar_pkg::CODE_W-1:0] key, input int gap);
        send_req(op, key, gap);
        predict_keys(op, key);
        for (int k = 0; k < step_n; k++)
            exp_put(step_buf[k]);
    endtask

    // result side: checks and ready pattern
    always @(posedge i_clk) begin
        t_emit want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (exp_wr == exp_rd) begin
                    report_mismatch("result with none pending", o_event_code, -1);
                end else begin
                    want = exp_buf[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (o_event_code !== want.code)
                        report_mismatch("event_code", o_event_code, want.code);
                    if (o_last !== want.last)
                        report_mismatch("last", o_last, want.last);
                end
            end
            rx_cyc <= rx_cyc + 1'b1;
            if (rx_hold_left != 0) begin
                i_ready      <= 1'b0;
                rx_hold_left <= rx_hold_left - 1;
            end else if (hold_ack != hold_req) begin
                hold_ack     <= hold_req;
                rx_hold_left <= RX_HOLD_CYC;
                i_ready      <= 1'b0;
            end else if (rx_stall_left != 0) begin
                i_ready       <= 1'b0;
                rx_stall_left <= rx_stall_left - 1;
            end else if (rx_cyc[8:7] == 2'b00 || $urandom_range(0, 3) != 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready       <= 1'b0;
                rx_stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(0, 2);
            end
        end
    end

    initial begin
        t_row                        row;
        int                          cnt;
        int                          r;
        bit                          calm;
        logic [mkar_pkg::OP_W-1:0]   op;
        logic [mkar_pkg::CODE_W-1:0] key;
        clear_keys();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[n]) begin
            row = dir_tab[n];
            if (row.kind == ROW_CFG) begin
                write_reg(row.idx, row.data);
            end else if (row.typed) begin
                send_req(row.op, row.key, pick_gap(1'b0));
                predict_keys(row.op, row.key);
                for (int k = 0; k < int'(row.exp_n); k++)
                    exp_put(t_emit'{row.exp_code, 1'b1});
            end else begin
                issue_req(row.op, row.key, pick_gap(1'b0));
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(mkar_pkg::CFG_DELAY, ph_delay[p]);
            write_reg(mkar_pkg::CFG_PERIOD, ph_period[p]);
            calm = ($urandom_range(0, 3) == 0);
            if (p == 2)
                hold_req++;
            cnt = 0;
            while (cnt < REQS_PER_PHASE) begin
                r   = $urandom_range(0, 99);
                key = KEY_W'($urandom_range(0, N_KEYS - 1));
                if (r < 25)
                    op = mkar_pkg::OP_PRESS;
                else if (r < 37)
                    op = mkar_pkg::OP_RELEASE;
                else if (r < 42)
                    op = OP_UNUSED;
                else
                    op = mkar_pkg::OP_TICK;
                issue_req(op, key, pick_gap(calm));
                if (op != OP_UNUSED)
                    cnt++;
            end
        end

        wait_idle();
        if (err_cnt == 0) begin
            $display("multi_key_auto_repeat test passed");
        end else begin
            $display("multi_key_auto_repeat test failed");
        end
        $finish;
    end

    initial begin
        #1500000;
        $display("multi_key_auto_repeat test failed");
        $finish;
    end

endmodule
